// ===== rtl/core/wpvd_pkg.sv =====
// Shared constants, codes and types of the window peak and valley detector.
`timescale 1ns / 1ps
`default_nettype none

package wpvd_pkg;

    // Default sizing of the design.
    localparam int MAX_HALF_WINDOW = 32;
    localparam int SAMPLE_WIDTH    = 16;
    localparam int POSITION_WIDTH  = 16;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 15;
    localparam int HALF_W      = 6;
    localparam int THR_W       = 15;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_WINDOW     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_THRESHOLD = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PEAK_ENABLE     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MINIMUM_ENABLE  = 2'd3;

    // Register values after reset.
    localparam logic [HALF_W-1:0] RST_HALF_WINDOW     = 6'd20;
    localparam logic [THR_W-1:0]  RST_LEVEL_THRESHOLD = 15'd128;
    localparam logic              RST_PEAK_ENABLE     = 1'b1;
    localparam logic              RST_MINIMUM_ENABLE  = 1'b1;

    // Extremum kinds.
    localparam logic KIND_MAX = 1'b0;
    localparam logic KIND_MIN = 1'b1;

    // Compare flags that one cell reports for the current center.
    typedef struct packed {
        logic above;
        logic below;
    } t_cell_flags;

endpackage

`default_nettype wire

// ===== rtl/core/wpvd_in_if.sv =====
// Input sample channel of the window peak and valley detector.
`timescale 1ns / 1ps
`default_nettype none

interface wpvd_in_if #(
    parameter int SAMPLE_WIDTH = wpvd_pkg::SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           first;

    modport source (output valid, sample, first, input ready);
    modport sink   (input valid, sample, first, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/wpvd_out_if.sv =====
// Result channel of the window peak and valley detector.
`timescale 1ns / 1ps
`default_nettype none

interface wpvd_out_if #(
    parameter int SAMPLE_WIDTH   = wpvd_pkg::SAMPLE_WIDTH,
    parameter int POSITION_WIDTH = wpvd_pkg::POSITION_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic [POSITION_WIDTH-1:0]      position;
    logic                           kind;
    logic signed [SAMPLE_WIDTH-1:0] level;

    modport source (output valid, position, kind, level, input ready);
    modport sink   (input valid, position, kind, level, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/wpvd_cell.sv =====
// One tap of the delay line with its own compare against the broadcast center.
`timescale 1ns / 1ps
`default_nettype none

module wpvd_cell #(
    parameter int MAX_HALF_WINDOW = wpvd_pkg::MAX_HALF_WINDOW,
    parameter int SAMPLE_WIDTH    = wpvd_pkg::SAMPLE_WIDTH,
    parameter int IDX             = 0
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_shift,
    input  wire logic signed [SAMPLE_WIDTH-1:0]       i_tap,
    input  wire logic [$clog2(MAX_HALF_WINDOW+1)-1:0] i_w,
    input  wire logic signed [SAMPLE_WIDTH-1:0]       i_center,
    input  wire logic                                 i_cmp_en,
    output logic signed [SAMPLE_WIDTH-1:0]            o_tap,
    output logic signed [SAMPLE_WIDTH-1:0]            o_sel,
    output wpvd_pkg::t_cell_flags                     o_flags
);

    logic signed [SAMPLE_WIDTH-1:0] r_tap;
    wpvd_pkg::t_cell_flags          r_flags;
    wpvd_pkg::t_cell_flags          n_flags;
    logic                           is_center;
    logic                           in_window;

    // Position of this tap relative to the current half window.
    assign is_center = (IDX == int'(i_w));
    assign in_window = !is_center && (IDX <= 2 * int'(i_w));

    // Sample moves one tap older on every shift.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_tap <= i_tap;
        end
    end

    // A tap outside the window never vetoes the center.
    always_comb begin
        n_flags.above = !in_window || (i_center > r_tap);
        n_flags.below = !in_window || (i_center < r_tap);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmp_en) begin
            r_flags <= n_flags;
        end
    end

    assign o_tap   = r_tap;
    assign o_sel   = is_center ? r_tap : '0;
    assign o_flags = r_flags;

endmodule

`default_nettype wire

// ===== rtl/core/window_peak_valley_detector_core.sv =====
// Top level: sliding-window peak and valley detector over a row of tap cells.
// A sample that can form a window passes through the accept, center select,
// compare in every cell and reduce steps; other samples are only accepted.
// No new sample is accepted until the previous one has left the reduce step.
// A full result register that is not taken holds the reduce step.
// Reset is synchronous and active low; it restores the registers and control
// state, while the taps are not cleared since stale taps are never compared.
`timescale 1ns / 1ps
`default_nettype none

module window_peak_valley_detector_core #(
    parameter int MAX_HALF_WINDOW = wpvd_pkg::MAX_HALF_WINDOW,
    parameter int SAMPLE_WIDTH    = wpvd_pkg::SAMPLE_WIDTH,
    parameter int POSITION_WIDTH  = wpvd_pkg::POSITION_WIDTH
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    wpvd_in_if.sink                                   i_in_ch,
    wpvd_out_if.source                                o_out_ch,
    input  wire logic                                 i_cfg_we,
    input  wire logic [wpvd_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire logic [wpvd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int DEPTH = 2 * MAX_HALF_WINDOW + 1;
    localparam int WW    = $clog2(MAX_HALF_WINDOW + 1);
    localparam int CW    = ((SAMPLE_WIDTH > wpvd_pkg::THR_W) ? SAMPLE_WIDTH
                                                            : wpvd_pkg::THR_W) + 2;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SEL  = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;
    localparam logic [1:0] ST_RED  = 2'd3;

    // Configuration registers.
    logic [wpvd_pkg::HALF_W-1:0] r_half_window;
    logic [wpvd_pkg::THR_W-1:0]  r_threshold;
    logic                        r_peak_en;
    logic                        r_min_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_window <= wpvd_pkg::RST_HALF_WINDOW;
            r_threshold   <= wpvd_pkg::RST_LEVEL_THRESHOLD;
            r_peak_en     <= wpvd_pkg::RST_PEAK_ENABLE;
            r_min_en      <= wpvd_pkg::RST_MINIMUM_ENABLE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                wpvd_pkg::CFG_HALF_WINDOW: begin
                    r_half_window <= i_cfg_data[wpvd_pkg::HALF_W-1:0];
                end
                wpvd_pkg::CFG_LEVEL_THRESHOLD: begin
                    r_threshold <= i_cfg_data[wpvd_pkg::THR_W-1:0];
                end
                wpvd_pkg::CFG_PEAK_ENABLE: begin
                    r_peak_en <= i_cfg_data[0];
                end
                wpvd_pkg::CFG_MINIMUM_ENABLE: begin
                    r_min_en <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Half window limited to what the delay line can hold.
    logic [WW-1:0] w_eff;
    assign w_eff = (int'(r_half_window) > MAX_HALF_WINDOW) ? WW'(MAX_HALF_WINDOW)
                                                           : WW'(r_half_window);

    // Control and per-sample registers.
    logic [1:0]                     r_state;
    logic [POSITION_WIDTH:0]        r_count;
    logic [WW-1:0]                  r_w;
    logic [POSITION_WIDTH-1:0]      r_pos;
    logic signed [SAMPLE_WIDTH-1:0] r_center;
    logic                           r_out_valid;
    logic [POSITION_WIDTH-1:0]      r_out_pos;
    logic                           r_out_kind;
    logic signed [SAMPLE_WIDTH-1:0] r_out_level;

    logic                      in_accept;
    logic [POSITION_WIDTH:0]   base_count;
    logic                      saturated;
    logic                      window_full;
    logic                      shift;

    assign i_in_ch.ready = i_rst_n && (r_state == ST_IDLE);
    assign in_accept     = i_in_ch.valid && i_in_ch.ready;
    assign base_count    = i_in_ch.first ? '0 : r_count;
    assign saturated     = base_count[POSITION_WIDTH];
    assign window_full   = (int'(base_count) >= 2 * int'(w_eff));
    assign shift         = in_accept && !saturated;

    // Row of tap cells; cell 0 takes the newest sample.
    logic signed [SAMPLE_WIDTH-1:0] taps [DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] sels [DEPTH];
    wpvd_pkg::t_cell_flags          flags [DEPTH];
    logic                           cmp_en;

    assign cmp_en = (r_state == ST_CMP);

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic signed [SAMPLE_WIDTH-1:0] tap_in;
        if (k == 0) begin : g_head
            assign tap_in = i_in_ch.sample;
        end else begin : g_link
            assign tap_in = taps[k-1];
        end
        wpvd_cell #(
            .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
            .SAMPLE_WIDTH    (SAMPLE_WIDTH),
            .IDX             (k)
        ) u_cell (
            .i_clk    (i_clk),
            .i_shift  (shift),
            .i_tap    (tap_in),
            .i_w      (r_w),
            .i_center (r_center),
            .i_cmp_en (cmp_en),
            .o_tap    (taps[k]),
            .o_sel    (sels[k]),
            .o_flags  (flags[k])
        );
    end

    // Only the center cell drives its tap onto the select bus.
    logic signed [SAMPLE_WIDTH-1:0] center_bus;
    logic                           all_above;
    logic                           all_below;

    always_comb begin
        center_bus = '0;
        all_above  = 1'b1;
        all_below  = 1'b1;
        for (int k = 0; k < DEPTH; k++) begin
            center_bus = center_bus | sels[k];
            all_above  = all_above & flags[k].above;
            all_below  = all_below & flags[k].below;
        end
    end

    // Threshold tests on a widened center.
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] thr_x;
    logic                 is_peak;
    logic                 is_valley;
    logic                 has_result;
    logic                 out_free;

    assign center_x   = CW'(r_center);
    assign thr_x      = $signed(CW'(r_threshold));
    assign is_peak    = all_above && (center_x > thr_x) && r_peak_en;
    assign is_valley  = all_below && (center_x < -thr_x) && r_min_en;
    assign has_result = is_peak || is_valley;
    assign out_free   = !r_out_valid || o_out_ch.ready;

    // Sequencer: accept, select center, compare in cells, reduce.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_count <= saturated ? base_count : base_count + 1'b1;
                        if (!saturated && window_full) begin
                            r_state <= ST_SEL;
                        end
                    end
                end
                ST_SEL: begin
                    r_state <= ST_CMP;
                end
                ST_CMP: begin
                    r_state <= ST_RED;
                end
                ST_RED: begin
                    if (!has_result || out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Window size and reported position are taken with the sample; the center in the select step.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_w   <= w_eff;
            r_pos <= base_count[POSITION_WIDTH-1:0] - POSITION_WIDTH'(w_eff);
        end
        if (r_state == ST_SEL) begin
            r_center <= center_bus;
        end
    end

    // Result register decouples the output from the sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_RED) && has_result && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_RED) && has_result && out_free) begin
            r_out_pos   <= r_pos;
            r_out_kind  <= is_peak ? wpvd_pkg::KIND_MAX : wpvd_pkg::KIND_MIN;
            r_out_level <= r_center;
        end
    end

    assign o_out_ch.valid    = r_out_valid;
    assign o_out_ch.position = r_out_pos;
    assign o_out_ch.kind     = r_out_kind;
    assign o_out_ch.level    = r_out_level;

endmodule

`default_nettype wire

// ===== rtl/core/wpvd_checker.sv =====
// Port-level checks of the detector, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module wpvd_checker #(
    parameter int SAMPLE_WIDTH   = wpvd_pkg::SAMPLE_WIDTH,
    parameter int POSITION_WIDTH = wpvd_pkg::POSITION_WIDTH
) (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           i_in_ready,
    input wire logic                           i_out_valid,
    input wire logic                           i_out_ready,
    input wire logic [POSITION_WIDTH-1:0]      i_out_position,
    input wire logic                           i_out_kind,
    input wire logic signed [SAMPLE_WIDTH-1:0] i_out_level
);

    logic in_accept;
    assign in_accept = i_in_valid && i_in_ready;

    // A result word stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped before it was taken");

    // A waiting result word keeps its fields until it is taken.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_position) && $stable(i_out_kind)
                                         && $stable(i_out_level))
        else $error("result word changed while it was waiting");

    // A fresh result must trace back to an accepted sample through the select, compare and reduce steps.
    a_out_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(in_accept, 4))
        else $error("result word without a sample accepted four cycles before");

    // A peak lies above zero and a valley below it, whatever the threshold.
    a_kind_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_out_kind == wpvd_pkg::KIND_MAX) && (i_out_level > 0))
                     || ((i_out_kind == wpvd_pkg::KIND_MIN) && (i_out_level < 0)))
        else $error("result kind does not match the sign of its level");

endmodule

bind window_peak_valley_detector_core wpvd_checker #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .POSITION_WIDTH (POSITION_WIDTH)
) u_wpvd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_ch.valid),
    .i_in_ready     (i_in_ch.ready),
    .i_out_valid    (o_out_ch.valid),
    .i_out_ready    (o_out_ch.ready),
    .i_out_position (o_out_ch.position),
    .i_out_kind     (o_out_ch.kind),
    .i_out_level    (o_out_ch.level)
);

`default_nettype wire

// ===== tb/window_peak_valley_detector_core_tb.sv =====
// Self-checking testbench of the window peak and valley detector core.
`timescale 1ns / 1ps

module window_peak_valley_detector_core_tb;

    import wpvd_pkg::*;

    localparam int TAP_COUNT     = 2 * MAX_HALF_WINDOW + 1;
    localparam int SET_LIMIT     = 1 << POSITION_WIDTH;
    localparam int SETTLE_CYCLES = 10;
    localparam int RANDOM_WORDS  = 1750;
    localparam int QUIET_TAIL    = 250;
    localparam int N_ROWS        = 31;

    // One reported extremum.
    typedef struct packed {
        logic [POSITION_WIDTH-1:0]      position;
        logic                           kind;
        logic signed [SAMPLE_WIDTH-1:0] level;
    } t_extremum;

    typedef enum logic [0:0] {ROW_WORD, ROW_CFG} t_row_op;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_GIVEN} t_row_chk;
    typedef enum logic [1:0] {WAVE_NOISE, WAVE_TIES, WAVE_TRIANGLE} t_wave;

    // One row of the directed table: a register write or a sample word.
    typedef struct packed {
        t_row_op                        op;
        logic [CFG_INDEX_W-1:0]         reg_index;
        logic [CFG_DATA_W-1:0]          reg_value;
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           first;
        t_row_chk                       chk;
        t_extremum                      want;
    } t_stim_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    wpvd_in_if  in_ch ();
    wpvd_out_if out_ch ();

    window_peak_valley_detector_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_ch     (in_ch),
        .o_out_ch    (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Directed table: reset window, extremes, thresholds, enables, set restarts.
    t_stim_row directed_rows [0:N_ROWS-1] = '{
        '{ROW_WORD, CFG_HALF_WINDOW, 15'd0, 16'sd30000, 1'b0, CHK_NONE,
          '{16'd0, KIND_MAX, 16'sd0}},
        '{ROW_CFG, CFG_HALF_WINDOW, 15'd0, 16'sd0, 1'b0, CHK_NONE,
          '{16'd0, KIND_MAX, 16'sd0}},
        '{ROW_CFG, CFG_LEVEL_THRESHOLD, 15'd0, 16'sd0, 1'b0, CHK_NONE,
          '{16'd0, KIND_MAX, 16'sd0}},
        '{ROW_WORD, CFG_HALF_WINDOW, 15'd0, 16'sd32767, 1'b1, CHK_GIVEN,
          '{16'd0, KIND_MAX, 16'sd32767}},
        '{ROW_WORD, CFG_HALF_WINDOW, 15'd0, 16'sh8000, 1'b0, CHK_GIVEN,
          '{16'd1, KIND_MIN, 16'sh8000}},
        '{ROW_WORD, CFG_HALF_WINDOW, 15'd0, 16'sd0, 1'b0, CHK_NONE,
          '{16'd0, KIND_MAX, 16'sd0}},
        '{ROW_WORD, CFG_HALF_WINDOW, 15'd0, 16'sd1, 1'b0, CHK_GIVEN,
          '{16'd3, KIND_MAX, 16'sd1}},
        '{ROW_WORD, CFG_HALF_WINDOW, 15'd0, -16'sd1, 1'b0, CHK_GIVEN,
          '{16'd4, KIND_MIN, -16'sd1}},
        '{ROW_CFG, CFG_LEVEL_THRESHOLD, 15'd32767, 16'sd0, 1'b0, CHK_NONE,
          '{16'd0, KIND_MAX, 16'sd0}},
        '{ROW_WORD, CFG_HALF_WINDOW, 15'd0, 16'sd32767, 1'b0, CHK_NONE,
          '{16'd0, KIND_MAX, 16'sd0}},
        '{ROW_WORD, CFG_HALF_WINDOW, 15'd0, 16'sh8000, 1'b0, CHK_GIVEN,
          '{16'd6, KIND_MIN, 16'sh8000}},
        '{ROW_WORD, CFG_HALF_WINDOW, 15'd0, -16'sd32767, 1'b0, CHK_NONE,
          '{16'd0, KIND_MAX, 16'sd0}},
        '{ROW_CFG, CFG_LEVEL_THRESHOLD, 15'd16, 16'sd0, 1'b0, CHK_NONE,
          '{16'd0, KIND_MAX, 16'sd0}},
        '{ROW_CFG, CFG_PEAK_ENABLE, 15'd0, 16'sd0, 1'b0, CHK_NONE,
          '{16'd0, KIND_MAX, 16'sd0}},
        '{ROW_WORD, CFG_HALF_WINDOW, 15'd0, 16'sd200, 1'b1, CHK_NONE,
          '{16'd0, KIND_MAX, 16'sd0}},
        '{ROW_WORD, CFG_HALF_WINDOW, 15'd0, -16'sd200, 1'b0, CHK_GIVEN,
          '{16'd1, KIND_MIN, -16'sd200}},
        '{ROW_CFG, CFG_PEAK_ENABLE, 15'd1, 16'sd0, 1'b0, CHK_NONE,
          '{16'd0, KIND_MAX, 16'sd0}},
        '{ROW_CFG, CFG_MINIMUM_ENABLE, 15'd0, 16'sd0, 1'b0, CHK_NONE,
          '{16'd0, KIND_MAX, 16'sd0}},
        '{ROW_WORD, CFG_HALF_WINDOW, 15'd0, -16'sd200, 1'b0, CHK_NONE,
          '{16'd0, KIND_MAX, 16'sd0}},
        '{ROW_WORD, CFG_HALF_WINDOW, 15'd0, 16'sd16, 1'b0, CHK_NONE,
          '{16'd0, KIND_MAX, 16'sd0}},
        '{ROW_WORD, CFG_HALF_WINDOW, 15'd0, 16'sd17, 1'b0, CHK_GIVEN,
          '{16'd4, KIND_MAX, 16'sd17}},
        '{ROW_CFG, CFG_MINIMUM_ENABLE, 15'd1, 16'sd0, 1'b0, CHK_NONE,
          '{16'd0, KIND_MAX, 16'sd0}},
        '{ROW_CFG, CFG_HALF_WINDOW, 15'd1, 16'sd0, 1'b0, CHK_NONE,
          '{16'd0, KIND_MAX, 16'sd0}},
        '{ROW_WORD, CFG_HALF_WINDOW, 15'd0, 16'sd5, 1'b1, CHK_NONE,
          '{16'd0, KIND_MAX, 16'sd0}},
        '{ROW_WORD, CFG_HALF_WINDOW, 15'd0, 16'sd300, 1'b0, CHK_NONE,
          '{16'd0, KIND_MAX, 16'sd0}},
        '{ROW_WORD, CFG_HALF_WINDOW, 15'd0, 16'sd10, 1'b0, CHK_GIVEN,
          '{16'd1, KIND_MAX, 16'sd300}},
        '{ROW_WORD, CFG_HALF_WINDOW, 15'd0, -16'sd500, 1'b1, CHK_NONE,
          '{16'd0, KIND_MAX, 16'sd0}},
        '{ROW_WORD, CFG_HALF_WINDOW, 15'd0, -16'sd900, 1'b0, CHK_NONE,
          '{16'd0, KIND_MAX, 16'sd0}},
        '{ROW_WORD, CFG_HALF_WINDOW, 15'd0, -16'sd400, 1'b0, CHK_GIVEN,
          '{16'd1, KIND_MIN, -16'sd900}},
        '{ROW_WORD, CFG_HALF_WINDOW, 15'd0, -16'sd400, 1'b0, CHK_MODEL,
          '{16'd0, KIND_MAX, 16'sd0}},
        '{ROW_WORD, CFG_HALF_WINDOW, 15'd0, -16'sd17, 1'b0, CHK_MODEL,
          '{16'd0, KIND_MAX, 16'sd0}}
    };

    // Mirror of the registers and the delay line.
    logic [HALF_W-1:0]              cfg_half;
    logic [THR_W-1:0]               cfg_thr;
    logic                           cfg_peak;
    logic                           cfg_min;
    logic signed [SAMPLE_WIDTH-1:0] sample_hist [0:TAP_COUNT-1];
    logic [POSITION_WIDTH:0]        set_len;

    t_extremum expected_extrema [$];

    bit    idle_on;
    int    rx_hold;
    int    err_count;
    int    n_words;
    int    n_peaks;
    int    n_valleys;
    int    n_cfg_writes;
    int    n_settings;

    // Waveform generator state for the random part.
    t_wave wave_mode;
    int    wave_val;
    int    wave_dir;
    int    wave_step;
    int    wave_lo;
    int    wave_hi;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shift one sample into the mirror and work out the extremum it exposes.
    function automatic bit detect_extremum(input logic signed [SAMPLE_WIDTH-1:0] s,
                                           input logic f, output t_extremum hit);
        int                             wh;
        int                             pos;
        bit                             above;
        bit                             below;
        logic signed [SAMPLE_WIDTH-1:0] center;
        hit = '0;
        if (f) begin
            set_len = '0;
        end
        // A saturated data set ignores everything until the next first flag.
        if (int'(set_len) >= SET_LIMIT) begin
            return 1'b0;
        end
        for (int k = TAP_COUNT - 1; k > 0; k--) begin
            sample_hist[k] = sample_hist[k-1];
        end
        sample_hist[0] = s;
        pos = int'(set_len);
        set_len = set_len + 1'b1;
        wh = (int'(cfg_half) > MAX_HALF_WINDOW) ? MAX_HALF_WINDOW : int'(cfg_half);
        if (int'(set_len) < 2 * wh + 1) begin
            return 1'b0;
        end
        center = sample_hist[wh];
        above = 1'b1;
        below = 1'b1;
        for (int j = 1; j <= wh; j++) begin
            if (!(center > sample_hist[wh-j] && center > sample_hist[wh+j])) begin
                above = 1'b0;
            end
            if (!(center < sample_hist[wh-j] && center < sample_hist[wh+j])) begin
                below = 1'b0;
            end
        end
        hit.position = POSITION_WIDTH'(pos - wh);
        hit.level    = center;
        if (above && int'(center) > int'(cfg_thr) && cfg_peak) begin
            hit.kind = KIND_MAX;
            return 1'b1;
        end
        if (below && int'(center) < -int'(cfg_thr) && cfg_min) begin
            hit.kind = KIND_MIN;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Offer one sample word and wait until it is taken.
    task automatic push_word(input logic signed [SAMPLE_WIDTH-1:0] s, input logic f,
                             input t_row_chk chk, input t_extremum given);
        t_extremum hit;
        bit        found;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.sample <= s;
        in_ch.first  <= f;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        found = detect_extremum(s, f, hit);
        case (chk)
            CHK_MODEL: begin
                if (found) begin
                    expected_extrema.push_back(hit);
                end
            end
            CHK_GIVEN: begin
                expected_extrema.push_back(given);
            end
            default: begin
            end
        endcase
        n_words++;
        @(negedge i_clk);
    endtask

    // Stop sending and let every outstanding result come out.
    task automatic drain_pipeline();
        in_ch.valid <= 1'b0;
        while (expected_extrema.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write one register and update the mirror.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        case (idx)
            CFG_HALF_WINDOW:     cfg_half = value[HALF_W-1:0];
            CFG_LEVEL_THRESHOLD: cfg_thr  = value[THR_W-1:0];
            CFG_PEAK_ENABLE:     cfg_peak = value[0];
            CFG_MINIMUM_ENABLE:  cfg_min  = value[0];
            default: begin
            end
        endcase
        n_cfg_writes++;
    endtask

    // Next random sample of the current waveform.
    task automatic make_sample(output logic signed [SAMPLE_WIDTH-1:0] s);
        int v;
        int nv;
        case (wave_mode)
            WAVE_NOISE: begin
                v = int'($urandom);
            end
            WAVE_TIES: begin
                v = int'($urandom_range(0, 6)) - 3;
            end
            default: begin
                nv = wave_val + wave_dir * wave_step;
                if (nv > wave_hi || nv < wave_lo) begin
                    wave_dir = -wave_dir;
                    nv = wave_val + wave_dir * wave_step;
                end
                wave_val = nv;
                v = wave_val;
                // Occasional jitter breaks the clean slopes.
                if ($urandom_range(0, 9) == 0) begin
                    v = v + int'($urandom_range(0, 16)) - 8;
                end
                if (v > 32767) begin
                    v = 32767;
                end
                if (v < -32768) begin
                    v = -32768;
                end
            end
        endcase
        s = v[SAMPLE_WIDTH-1:0];
    endtask

    // Result side: random stall bursts while idling is on.
    always @(negedge i_clk) begin
        if (rx_hold != 0) begin
            out_ch.ready <= 1'b0;
            rx_hold      <= rx_hold - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            out_ch.ready <= 1'b0;
            rx_hold      <= $urandom_range(0, 10);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Compare every accepted result word with the oldest expectation.
    always @(posedge i_clk) begin
        t_extremum want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_extrema.size() == 0) begin
                $error("unexpected result word: position %0d kind %0d level %0d",
                       out_ch.position, out_ch.kind, out_ch.level);
                err_count++;
            end else begin
                want = expected_extrema.pop_front();
                if (out_ch.position !== want.position) begin
                    $error("position: expected %0d, actual %0d",
                           want.position, out_ch.position);
                    err_count++;
                end
                if (out_ch.kind !== want.kind) begin
                    $error("kind: expected %0d, actual %0d", want.kind, out_ch.kind);
                    err_count++;
                end
                if (out_ch.level !== want.level) begin
                    $error("level: expected %0d, actual %0d", want.level, out_ch.level);
                    err_count++;
                end
                if (want.kind == KIND_MAX) begin
                    n_peaks++;
                end else begin
                    n_valleys++;
                end
            end
        end
    end

    // Main sequence.
    initial begin
        logic signed [SAMPLE_WIDTH-1:0] s;
        logic                           f;
        int                             phase;
        int                             sent_random;
        int                             len;
        int                             w;
        int                             w_eff;
        int                             thr;
        int                             span;
        int                             first_odds;
        bit                             pk;
        bit                             mn;
        bit                             phase_idle;

        in_ch.valid  = 1'b0;
        in_ch.sample = '0;
        in_ch.first  = 1'b0;
        out_ch.ready = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_rst_n      = 1'b0;
        idle_on      = 1'b0;
        rx_hold      = 0;
        err_count    = 0;
        n_words      = 0;
        n_peaks      = 0;
        n_valleys    = 0;
        n_cfg_writes = 0;
        n_settings   = 0;
        cfg_half     = RST_HALF_WINDOW;
        cfg_thr      = RST_LEVEL_THRESHOLD;
        cfg_peak     = RST_PEAK_ENABLE;
        cfg_min      = RST_MINIMUM_ENABLE;
        set_len      = '0;
        for (int k = 0; k < TAP_COUNT; k++) begin
            sample_hist[k] = '0;
        end
        wave_mode = WAVE_NOISE;
        wave_val  = 0;
        wave_dir  = 1;
        wave_step = 1;
        wave_lo   = -32768;
        wave_hi   = 32767;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table.
        for (int r = 0; r < N_ROWS; r++) begin
            if (directed_rows[r].op == ROW_CFG) begin
                drain_pipeline();
                write_reg(directed_rows[r].reg_index, directed_rows[r].reg_value);
            end else begin
                push_word(directed_rows[r].sample, directed_rows[r].first,
                          directed_rows[r].chk, directed_rows[r].want);
            end
        end
        n_settings++;

        // Random phases, each with its own register setting and waveform.
        phase = 0;
        sent_random = 0;
        while (sent_random < RANDOM_WORDS) begin
            pk = 1'b1;
            mn = 1'b1;
            case (phase)
                0: begin
                    w = 63;
                    thr = 0;
                    wave_mode = WAVE_TRIANGLE;
                end
                1: begin
                    w = 32;
                    thr = 0;
                    wave_mode = WAVE_TRIANGLE;
                end
                2: begin
                    w = 0;
                    thr = 32767;
                    wave_mode = WAVE_NOISE;
                end
                3: begin
                    w = 2;
                    thr = 1;
                    wave_mode = WAVE_TIES;
                end
                4: begin
                    w = 33;
                    thr = 200;
                    pk = 1'b0;
                    wave_mode = WAVE_TRIANGLE;
                end
                default: begin
                    case ($urandom_range(0, 7))
                        0:       w = 0;
                        1, 2, 3: w = $urandom_range(1, 3);
                        4:       w = $urandom_range(4, 12);
                        5:       w = 32;
                        6:       w = $urandom_range(33, 63);
                        default: w = $urandom_range(0, 63);
                    endcase
                    case ($urandom_range(0, 5))
                        0:       thr = 0;
                        1:       thr = 32767;
                        2:       thr = $urandom_range(0, 32767);
                        default: thr = $urandom_range(0, 1023);
                    endcase
                    pk = ($urandom_range(0, 4) != 0);
                    mn = ($urandom_range(0, 4) != 0);
                    case ($urandom_range(0, 5))
                        0:       wave_mode = WAVE_NOISE;
                        1:       wave_mode = WAVE_TIES;
                        default: wave_mode = WAVE_TRIANGLE;
                    endcase
                    if (wave_mode == WAVE_TIES) begin
                        thr = $urandom_range(0, 2);
                    end
                end
            endcase
            w_eff = (w > MAX_HALF_WINDOW) ? MAX_HALF_WINDOW : w;

            // Triangle whose half period spans more than the half window.
            span      = $urandom_range(64, 65535);
            wave_lo   = -32768 + int'($urandom_range(0, 65535 - span));
            wave_hi   = wave_lo + span;
            wave_val  = wave_lo + int'($urandom_range(0, span));
            wave_dir  = 1;
            wave_step = span / int'($urandom_range(w_eff + 1, 3 * w_eff + 8));
            if (wave_step < 1) begin
                wave_step = 1;
            end

            idle_on = 1'b0;
            drain_pipeline();
            write_reg(CFG_HALF_WINDOW, CFG_DATA_W'(w));
            write_reg(CFG_LEVEL_THRESHOLD, CFG_DATA_W'(thr));
            write_reg(CFG_PEAK_ENABLE, CFG_DATA_W'(pk));
            write_reg(CFG_MINIMUM_ENABLE, CFG_DATA_W'(mn));
            n_settings++;

            phase_idle = ($urandom_range(0, 3) != 0);
            len        = (w_eff >= 20) ? $urandom_range(200, 300) : $urandom_range(80, 160);
            first_odds = 60 + 8 * w_eff;
            for (int k = 0; k < len && sent_random < RANDOM_WORDS; k++) begin
                idle_on = phase_idle && (sent_random < RANDOM_WORDS - QUIET_TAIL);
                f = (k == 0 && $urandom_range(0, 1) == 1) ||
                    ($urandom_range(0, first_odds) == 0);
                make_sample(s);
                push_word(s, f, CHK_MODEL, '0);
                sent_random++;
            end
            phase++;
        end

        idle_on = 1'b0;
        drain_pipeline();

        $display("Covered %0d sample words under %0d register settings (%0d writes).",
                 n_words, n_settings, n_cfg_writes);
        $display("Checked %0d peaks and %0d valleys across windows, thresholds and stalls.",
                 n_peaks, n_valleys);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
